// ===== rtl/core/bootp_vendor_option_parser_assert.svh =====
// Assertion macros for the BOOTP vendor option parser.
`ifndef BOOTP_VENDOR_OPTION_PARSER_ASSERT_SVH
`define BOOTP_VENDOR_OPTION_PARSER_ASSERT_SVH
`ifndef SYNTHESIS
`define BVOP_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);
`define BVOP_ASSERT_NORST(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) prop) else $error(msg);
`else
`define BVOP_ASSERT(lbl, clk_s, rst_s, prop, msg)
`define BVOP_ASSERT_NORST(lbl, clk_s, prop, msg)
`endif
`endif

// ===== rtl/core/bvop_pkg.sv =====
package bvop_pkg;

  localparam int DEF_VENDOR_BYTES = 64;
  localparam int ADDR_BYTES       = 4;
  localparam int QUEUE_DEPTH      = 4;
  localparam int QPTR_W           = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W           = $clog2(QUEUE_DEPTH + 1);

  localparam logic [31:0] MAGIC_COOKIE = 32'h6382_5363;
  localparam logic [7:0]  TAG_PAD      = 8'd0;
  localparam logic [7:0]  TAG_END      = 8'd255;
  localparam logic [7:0]  TAG_MASK     = 8'd1;
  localparam logic [7:0]  TAG_GATEWAY  = 8'd3;
  localparam logic [7:0]  TAG_TIME     = 8'd4;
  localparam logic [7:0]  TAG_NAME     = 8'd6;
  localparam logic [7:0]  TAG_PRINTER  = 8'd9;
  localparam logic [7:0]  TAG_FILE     = 8'd11;

  typedef enum logic [2:0] {
    KIND_MASK    = 3'd0,
    KIND_GATEWAY = 3'd1,
    KIND_TIME    = 3'd2,
    KIND_NAME    = 3'd3,
    KIND_FILE    = 3'd4,
    KIND_PRINTER = 3'd5,
    KIND_DONE    = 3'd6,
    KIND_BAD     = 3'd7
  } kind_t;

  // one queue entry: a result, optionally followed by a done result
  typedef struct packed {
    kind_t       kind;
    logic [31:0] address;
    logic        tail_done;
  } res_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic tag_known(input logic [7:0] tag);
    logic known;
    case (tag)
      TAG_MASK, TAG_GATEWAY, TAG_TIME, TAG_NAME, TAG_FILE, TAG_PRINTER: known = 1'b1;
      default: known = 1'b0;
    endcase
    return known;
  endfunction

  function automatic kind_t tag_kind(input logic [7:0] tag);
    kind_t k;
    case (tag)
      TAG_GATEWAY: k = KIND_GATEWAY;
      TAG_TIME:    k = KIND_TIME;
      TAG_NAME:    k = KIND_NAME;
      TAG_FILE:    k = KIND_FILE;
      TAG_PRINTER: k = KIND_PRINTER;
      default:     k = KIND_MASK;
    endcase
    return k;
  endfunction

endpackage

// ===== rtl/core/bvop_front.sv =====
module bvop_front #(
  parameter int VENDOR_BYTES = bvop_pkg::DEF_VENDOR_BYTES
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           byte_value,
  input  logic                 area_start,
  output logic                 q_push,
  output bvop_pkg::res_entry_t q_entry,
  input  bvop_pkg::q_stat_t    q_stat
);
  import bvop_pkg::*;

  localparam int OFF_W = $clog2(VENDOR_BYTES);

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_COOKIE = 6'b000010,
    PH_TAG    = 6'b000100,
    PH_LEN    = 6'b001000,
    PH_BODY   = 6'b010000,
    PH_DONE   = 6'b100000
  } phase_t;

  phase_t           phase, phase_next, eff_phase;
  logic [OFF_W-1:0] area_offset, area_offset_next, pos;
  logic [31:0]      cookie_shift, cookie_shift_next;
  logic [7:0]       current_tag, current_tag_next;
  logic [7:0]       bytes_remaining, bytes_remaining_next;
  logic [31:0]      capture_word, capture_word_next;
  logic [2:0]       capture_count, capture_count_next;
  logic             take, active;
  logic             r0_valid, end_done;
  kind_t            r0_kind;
  logic [31:0]      r0_addr;

  assign in_ready = !q_stat.full;
  assign take     = in_valid && in_ready;

  always_comb begin
    phase_next           = phase;
    area_offset_next     = area_offset;
    cookie_shift_next    = cookie_shift;
    current_tag_next     = current_tag;
    bytes_remaining_next = bytes_remaining;
    capture_word_next    = capture_word;
    capture_count_next   = capture_count;
    r0_valid             = 1'b0;
    r0_kind              = KIND_DONE;
    r0_addr              = '0;
    end_done             = 1'b0;
    active    = area_start || (phase inside {PH_COOKIE, PH_TAG, PH_LEN, PH_BODY});
    eff_phase = area_start ? PH_COOKIE : phase;
    pos       = area_start ? '0 : area_offset;
    if (take && active) begin
      case (eff_phase)
        PH_COOKIE: begin
          cookie_shift_next = {cookie_shift[23:0], byte_value};
          if (pos >= OFF_W'(ADDR_BYTES - 1)) begin
            if (cookie_shift_next == MAGIC_COOKIE) begin
              phase_next = PH_TAG;
            end else begin
              r0_valid   = 1'b1;
              r0_kind    = KIND_BAD;
              phase_next = PH_DONE;
            end
          end else begin
            phase_next = PH_COOKIE;
          end
        end
        PH_TAG: begin
          if (byte_value == TAG_END) begin
            r0_valid   = 1'b1;
            r0_kind    = KIND_DONE;
            phase_next = PH_DONE;
          end else if (byte_value != TAG_PAD) begin
            current_tag_next = byte_value;
            phase_next       = PH_LEN;
          end
        end
        PH_LEN: begin
          capture_word_next = '0;
          if (current_tag == TAG_MASK) begin
            // mask ignores its length byte and takes the next four bytes
            bytes_remaining_next = 8'(ADDR_BYTES);
            capture_count_next   = '0;
            phase_next           = PH_BODY;
          end else begin
            bytes_remaining_next = byte_value;
            capture_count_next = (tag_known(current_tag) && byte_value >= 8'(ADDR_BYTES)) ?
                                 3'd0 : 3'(ADDR_BYTES);
            phase_next = (byte_value != 8'd0) ? PH_BODY : PH_TAG;
          end
        end
        PH_BODY: begin
          if (capture_count < 3'(ADDR_BYTES)) begin
            capture_word_next  = {capture_word[23:0], byte_value};
            capture_count_next = capture_count + 3'd1;
            if (capture_count_next == 3'(ADDR_BYTES) && tag_known(current_tag)) begin
              r0_valid = 1'b1;
              r0_kind  = (current_tag == TAG_MASK) ? KIND_MASK : tag_kind(current_tag);
              r0_addr  = capture_word_next;
            end
          end
          bytes_remaining_next = (bytes_remaining != 8'd0) ? bytes_remaining - 8'd1 : 8'd0;
          if (bytes_remaining_next == 8'd0) begin
            phase_next = PH_TAG;
          end
        end
        default: ;
      endcase
      area_offset_next = pos + OFF_W'(1);
      // last byte of the area closes the parse
      if (phase_next != PH_DONE && pos == OFF_W'(VENDOR_BYTES - 1)) begin
        end_done   = 1'b1;
        phase_next = PH_DONE;
      end
    end
  end

  assign q_push            = take && (r0_valid || end_done);
  assign q_entry.kind      = r0_valid ? r0_kind : KIND_DONE;
  assign q_entry.address   = r0_valid ? r0_addr : 32'd0;
  assign q_entry.tail_done = r0_valid && end_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      area_offset <= '0;
    end else begin
      phase       <= phase_next;
      area_offset <= area_offset_next;
    end
  end

  always_ff @(posedge clk) begin
    cookie_shift    <= cookie_shift_next;
    current_tag     <= current_tag_next;
    bytes_remaining <= bytes_remaining_next;
    capture_word    <= capture_word_next;
    capture_count   <= capture_count_next;
  end

endmodule

// ===== rtl/core/bvop_queue.sv =====
module bvop_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  bvop_pkg::res_entry_t push_entry,
  input  logic                 pop,
  output bvop_pkg::res_entry_t head,
  output bvop_pkg::q_stat_t    stat
);
  import bvop_pkg::*;

  res_entry_t        mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign stat.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/core/bvop_back.sv =====
module bvop_back (
  input  logic                 clk,
  input  logic                 rst,
  input  bvop_pkg::res_entry_t q_head,
  input  bvop_pkg::q_stat_t    q_stat,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output bvop_pkg::kind_t      out_kind,
  output logic [31:0]          out_address,
  output logic                 out_last
);
  import bvop_pkg::*;

  logic load;
  logic pend_done;  // a trailing done result still owed

  assign load  = !out_valid || out_ready;
  assign q_pop = load && !pend_done && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pend_done <= 1'b0;
    end else if (load) begin
      if (pend_done) begin
        out_valid <= 1'b1;
        pend_done <= 1'b0;
      end else if (!q_stat.empty) begin
        out_valid <= 1'b1;
        pend_done <= q_head.tail_done;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pend_done) begin
        out_kind    <= KIND_DONE;
        out_address <= 32'd0;
        out_last    <= 1'b1;
      end else if (!q_stat.empty) begin
        out_kind    <= q_head.kind;
        out_address <= q_head.address;
        out_last    <= !q_head.tail_done;
      end
    end
  end

endmodule

// ===== rtl/core/bootp_vendor_option_parser.sv =====
// BOOTP vendor-area option parser. Feed the vendor area one byte per transfer,
// with s_tuser high on its first byte (the first magic cookie byte); that bit
// restarts the parse at any time. Bytes outside an area are dropped silently.
// After the cookie 99.130.83.99 the TLV options are walked: pad is skipped,
// end or the last byte of the area (VENDOR_BYTES) gives a done result, a bad
// cookie gives a bad-cookie result. Subnet mask always takes the four bytes
// after its length byte; gateway, time, name, resource-location and printer
// server options report their first four bytes as an address when their
// length is at least four. Results leave on the master side with the kind in
// m_tuser, the address (first byte most significant, zero for done and bad
// cookie) in m_tdata, and m_tlast on the last result caused by one byte.
// Rate: one byte per clock; the parser decides each byte in the cycle it is
// taken. Results go through a four-entry queue and then an output register,
// so a result is offered on the master side only after passing both, and the byte
// side stalls only when that queue is full. The output side sends one result per
// clock while m_tready is high; a byte that causes two results (an address and
// done) gives two result transfers, the done result second.
`include "bootp_vendor_option_parser_assert.svh"
module bootp_vendor_option_parser #(
  parameter int VENDOR_BYTES = bvop_pkg::DEF_VENDOR_BYTES
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_value
  input  logic        s_tuser,   // [0] area_start
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] address
  output logic [2:0]  m_tuser,   // [2:0] result_kind
  output logic        m_tlast    // last_of_run
);
  import bvop_pkg::*;

  logic       q_push, q_pop;
  res_entry_t q_entry, q_head;
  q_stat_t    q_stat;
  kind_t      out_kind;

  // front: per-byte parse state machine
  bvop_front #(
    .VENDOR_BYTES(VENDOR_BYTES)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .byte_value (s_tdata),
    .area_start (s_tuser),
    .q_push     (q_push),
    .q_entry    (q_entry),
    .q_stat     (q_stat)
  );

  // result queue between parse and output
  bvop_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  // back: splits an entry into one or two result transfers
  bvop_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_head      (q_head),
    .q_stat      (q_stat),
    .q_pop       (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_kind    (out_kind),
    .out_address (m_tdata),
    .out_last    (m_tlast)
  );

  assign m_tuser = 3'(out_kind);

  `BVOP_ASSERT(a_push_room, clk, rst, q_push |-> !q_stat.full, "result pushed into a full queue")
  `BVOP_ASSERT_NORST(a_rst_quiet, clk, rst |=> !m_tvalid, "result offered right after reset")
  `BVOP_ASSERT(a_done_zero, clk, rst, (m_tvalid && (out_kind == KIND_DONE)) |-> (m_tdata == 32'd0), "done result with nonzero address")
  `BVOP_ASSERT(a_bad_last, clk, rst, (m_tvalid && (out_kind == KIND_BAD)) |-> (m_tlast && (m_tdata == 32'd0)), "bad cookie result not alone or nonzero")

endmodule
